// ===== hw/rtl/pdsr_pkg.sv =====
`default_nettype none

package pdsr_pkg;

  // Field widths
  localparam int CFG_W    = 16;
  localparam int TGT_W    = 16;
  localparam int TIME_W   = 32;
  localparam int PROD_W   = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  // Default parameter values
  localparam int DEF_DUTY_BITS = 16;
  localparam int DEF_TIME_BITS = 32;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_DUTY_MAX  = 16'd1023;
  localparam logic [CFG_W-1:0] RST_RAMP_STEP = 16'd1;
  localparam logic [CFG_W-1:0] RST_MIN_DIST  = 16'd16;
  localparam logic [CFG_W-1:0] RST_RAMP_TIME = 16'd500;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DUTY_MAX  = 2'd0,
    REG_RAMP_STEP = 2'd1,
    REG_MIN_DIST  = 2'd2,
    REG_RAMP_TIME = 2'd3
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pdsr_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend shifts out
// of the top of the quotient register while quotient bits shift in below.
module pdsr_div
  import pdsr_pkg::*;
#(
  parameter int DIVISOR_BITS = DEF_DUTY_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [PROD_W-1:0]       dividend,
  input  wire logic [DIVISOR_BITS-1:0] divisor,
  output logic                         done,
  output logic [PROD_W-1:0]            quotient
);

  localparam int CNT_W = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic [PROD_W-1:0]       qreg;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] dvs;

  logic [DIVISOR_BITS:0]   trial;
  logic [DIVISOR_BITS:0]   diff;
  logic                    fits;

  // One restoring step
  always_comb begin
    trial = {rem, qreg[PROD_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        qreg <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        qreg <= {qreg[PROD_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = qreg;

endmodule

`default_nettype wire

// ===== hw/rtl/pwm_duty_slew_ramp_core.sv =====
// Sequencing: an accepted input goes to ST_UPDATE, through ST_DIV first when the
// step period is divided out; the result is registered in ST_UPDATE.
// Flow: one transaction in flight; a new input is taken only back in ST_IDLE, after
// the bit-serial period divider where it is used; result stalls hold ST_UPDATE.
// Reset (rst, synchronous): registers to their defaults, ramp state and current
// duty cleared, output empty; the output compare register is not cleared.
`default_nettype none

module pwm_duty_slew_ramp_core
  import pdsr_pkg::*;
#(
  parameter int DUTY_BITS = DEF_DUTY_BITS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_data,
  // input stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // [15:0] target_duty, [47:16] time_ms, [48] smooth_request, zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // result stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [15:0] compare_value, [16] ramp_done, [17] stepped, zero fill
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  localparam logic [CFG_W-1:0] DUTY_LIM = CFG_W'((32'd1 << DUTY_BITS) - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPDATE
  } state_t;

  state_t state;

  // Configuration registers
  logic [CFG_W-1:0] duty_max;
  logic [CFG_W-1:0] ramp_step;
  logic [CFG_W-1:0] min_dist;
  logic [CFG_W-1:0] ramp_time;

  // Ramp state
  logic [DUTY_BITS-1:0] duty_now;
  logic [DUTY_BITS-1:0] start_distance;
  logic                 smooth_active;
  logic [TIME_BITS-1:0] last_update_time;

  // Per-transaction holding registers
  logic [DUTY_BITS-1:0] tgt;
  logic [DUTY_BITS-1:0] item_dist;
  logic [TIME_BITS-1:0] now;
  logic                 jump;
  logic [PROD_W-1:0]    period;

  // Output register
  logic [DUTY_BITS-1:0] out_compare;
  logic                 out_done;
  logic                 out_stepped;

  // Input decode and first-step decisions
  logic [TGT_W-1:0]     in_target;
  logic [TIME_BITS-1:0] in_time;
  logic                 in_req;
  logic [CFG_W-1:0]     lim;
  logic [TGT_W-1:0]     tgt_clamped;
  logic [DUTY_BITS-1:0] tgt_in;
  logic [DUTY_BITS-1:0] dist_in;
  logic                 sa_eff;
  logic [DUTY_BITS-1:0] sd_eff;
  logic                 jump_in;
  logic                 accept;

  always_comb begin
    in_target   = s_tdata[TGT_W-1:0];
    in_time     = s_tdata[TGT_W +: TIME_BITS];
    in_req      = s_tdata[TGT_W + TIME_W];
    lim         = (duty_max > DUTY_LIM) ? DUTY_LIM : duty_max;
    tgt_clamped = (in_target < lim) ? in_target : lim;
    tgt_in      = tgt_clamped[DUTY_BITS-1:0];
    dist_in     = (duty_now > tgt_in) ? (duty_now - tgt_in) : (tgt_in - duty_now);
    sa_eff      = smooth_active | in_req;
    sd_eff      = (start_distance == '0) ? dist_in : start_distance;
    jump_in     = !sa_eff || (CFG_W'(sd_eff) < min_dist);
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Period divider: ramp_time * ramp_step / start_distance
  logic              div_start;
  logic              div_done;
  logic [PROD_W-1:0] div_quot;
  logic [PROD_W-1:0] product;

  assign product   = PROD_W'(ramp_time) * PROD_W'(ramp_step);
  assign div_start = accept && !jump_in && (sd_eff != '0);

  pdsr_div #(
    .DIVISOR_BITS(DUTY_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (sd_eff),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Timed update decisions
  logic [TIME_BITS-1:0] elapsed;
  logic                 due;
  logic                 far;
  logic                 out_free;
  logic [DUTY_BITS-1:0] duty_up;
  logic [DUTY_BITS-1:0] duty_dn;
  logic [DUTY_BITS-1:0] step_val;
  logic                 upd_finish;
  logic                 upd_move;
  logic                 upd_stepped;
  logic [DUTY_BITS-1:0] upd_compare;

  always_comb begin
    elapsed     = now - last_update_time;
    due         = (PROD_W'(elapsed) >= period);
    far         = (CFG_W'(item_dist) > ramp_step);
    out_free    = !m_tvalid || m_tready;
    duty_up     = duty_now + ramp_step[DUTY_BITS-1:0];
    duty_dn     = duty_now - ramp_step[DUTY_BITS-1:0];
    step_val    = (duty_now < tgt) ? duty_up : duty_dn;
    // jump, or a timed update within one step: snap and end the ramp
    upd_finish  = jump || (due && !far);
    upd_move    = !jump && due && far;
    upd_stepped = !jump && due;
    upd_compare = upd_finish ? tgt : (upd_move ? step_val : duty_now);
  end

  // Control, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      duty_max         <= RST_DUTY_MAX;
      ramp_step        <= RST_RAMP_STEP;
      min_dist         <= RST_MIN_DIST;
      ramp_time        <= RST_RAMP_TIME;
      duty_now         <= '0;
      start_distance   <= '0;
      smooth_active    <= 1'b0;
      last_update_time <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_DUTY_MAX:  duty_max  <= cfg_data;
          REG_RAMP_STEP: ramp_step <= cfg_data;
          REG_MIN_DIST:  min_dist  <= cfg_data;
          REG_RAMP_TIME: ramp_time <= cfg_data;
          default: ;
        endcase
      end

      if ((state == ST_UPDATE) && out_free) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            smooth_active  <= sa_eff;
            start_distance <= sd_eff;
            tgt            <= tgt_in;
            item_dist      <= dist_in;
            now            <= in_time;
            jump           <= jump_in;
            period         <= '0;
            state          <= div_start ? ST_DIV : ST_UPDATE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            period <= div_quot;
            state  <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            out_compare <= upd_compare;
            out_done    <= upd_finish;
            out_stepped <= upd_stepped;
            if (upd_finish) begin
              duty_now       <= tgt;
              start_distance <= '0;
              smooth_active  <= 1'b0;
            end else if (upd_move) begin
              duty_now <= step_val;
            end
            if (upd_stepped) last_update_time <= now;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {(OUT_TDATA_W - TGT_W - 2)'(0), out_stepped, out_done,
                    TGT_W'(out_compare)};

endmodule

`default_nettype wire

// ===== tb/sv/tb_pwm_duty_slew_ramp_core.sv =====
`default_nettype none

module tb_pwm_duty_slew_ramp_core;
  import pdsr_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 57;
  localparam int SETTLE_CYCLES   = 40;
  localparam int MAX_PRINTED     = 100;

  // one request and one result, packed as on the buses (last field lowest)
  typedef struct packed {
    logic              smooth;
    logic [TIME_W-1:0] now_ms;
    logic [TGT_W-1:0]  target;
  } slew_req_t;

  typedef struct packed {
    logic             stepped;
    logic             ramp_done;
    logic [TGT_W-1:0] compare_value;
  } slew_res_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_addr = REG_DUTY_MAX;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  pwm_duty_slew_ramp_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies and ramp state of the duty predictor
  logic [CFG_W-1:0]  duty_max_r  = RST_DUTY_MAX;
  logic [CFG_W-1:0]  ramp_step_r = RST_RAMP_STEP;
  logic [CFG_W-1:0]  min_dist_r  = RST_MIN_DIST;
  logic [CFG_W-1:0]  ramp_time_r = RST_RAMP_TIME;
  logic [TGT_W-1:0]  duty_now_q  = '0;
  logic [TGT_W-1:0]  start_dist_q = '0;
  logic              smooth_on_q = 1'b0;
  logic [TIME_W-1:0] last_step_ms_q = '0;

  slew_req_t req_queue[$];
  slew_res_t duty_expect_q[$];
  slew_req_t cur_req;
  bit        req_taken = 1'b0;
  int        idle_pct = 38;
  int        n_added = 0;
  int        n_accepted = 0;
  int        n_results = 0;
  int        n_steps = 0;
  int        n_done = 0;
  int        mismatches = 0;
  int        cycle_cnt = 0;

  // stimulus generator state
  logic [TIME_W-1:0] gen_ms = '0;
  logic [TGT_W-1:0]  gen_last_tgt = '0;

  // compute the next compare value and update the ramp state
  task automatic slew_predict(input slew_req_t rq, output slew_res_t rs);
    logic [TGT_W-1:0]  valid_tgt;
    logic [TGT_W-1:0]  cur_dist;
    logic [PROD_W-1:0] period;
    logic [TIME_W-1:0] elapsed;
    valid_tgt = (rq.target < duty_max_r) ? rq.target : duty_max_r;
    cur_dist = (duty_now_q > valid_tgt) ? duty_now_q - valid_tgt : valid_tgt - duty_now_q;
    rs = '0;
    if (rq.smooth) smooth_on_q = 1'b1;
    if (start_dist_q == 0) start_dist_q = cur_dist;
    if (!smooth_on_q || start_dist_q < min_dist_r) begin
      duty_now_q = valid_tgt;
      start_dist_q = '0;
      smooth_on_q = 1'b0;
      rs.ramp_done = 1'b1;
    end else begin
      period = '0;
      if (start_dist_q != 0)
        period = (PROD_W'(ramp_time_r) * PROD_W'(ramp_step_r)) / PROD_W'(start_dist_q);
      elapsed = rq.now_ms - last_step_ms_q;
      if (elapsed >= period) begin
        last_step_ms_q = rq.now_ms;
        rs.stepped = 1'b1;
        if (cur_dist > ramp_step_r) begin
          if (duty_now_q < valid_tgt) duty_now_q = duty_now_q + ramp_step_r;
          else duty_now_q = duty_now_q - ramp_step_r;
        end else begin
          duty_now_q = valid_tgt;
          start_dist_q = '0;
          smooth_on_q = 1'b0;
          rs.ramp_done = 1'b1;
        end
      end
    end
    rs.compare_value = duty_now_q;
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("tb: %s mismatch on result %0d: expected %0h, got %0h",
               field, n_results, want, got);
  endtask

  // driver: new request and ready decisions at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || req_taken) begin
        req_taken = 1'b0;
        if (req_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_req = req_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= IN_TDATA_W'(cur_req);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // monitor: check results, then predict for each accepted request
  always @(posedge clk) begin
    slew_res_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(slew_res_t)-1:0];
        if (duty_expect_q.size() == 0) begin
          report_mismatch("unexpected result", 0, got);
        end else begin
          want = duty_expect_q.pop_front();
          if (got.compare_value !== want.compare_value)
            report_mismatch("compare_value", want.compare_value, got.compare_value);
          if (got.ramp_done !== want.ramp_done)
            report_mismatch("ramp_done", want.ramp_done, got.ramp_done);
          if (got.stepped !== want.stepped)
            report_mismatch("stepped", want.stepped, got.stepped);
          n_steps += want.stepped;
          n_done += want.ramp_done;
        end
        n_results++;
      end
      if (s_tvalid && s_tready) begin
        slew_predict(cur_req, want);
        duty_expect_q.push_back(want);
        n_accepted++;
        req_taken = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results pending",
               cycle_cnt, duty_expect_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_req(input logic [TGT_W-1:0] tgt, input logic [TIME_W-1:0] ms,
                         input logic smooth);
    slew_req_t rq;
    rq.target = tgt;
    rq.now_ms = ms;
    rq.smooth = smooth;
    req_queue.push_back(rq);
    n_added++;
  endtask

  // block until every request is accepted and answered
  task automatic drain();
    while (n_accepted != n_added || duty_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_DUTY_MAX:  duty_max_r = val;
      REG_RAMP_STEP: ramp_step_r = val;
      REG_MIN_DIST:  min_dist_r = val;
      REG_RAMP_TIME: ramp_time_r = val;
      default: ;
    endcase
  endtask

  // ramp sequences: a target held over several timestamps, plus some noise
  task automatic gen_phase(input int n);
    int made;
    int len;
    int k;
    int r;
    bit noisy;
    logic smooth;
    logic [TGT_W-1:0] tgt;
    logic [TGT_W-1:0] a;
    logic [TGT_W-1:0] b;
    longint dg;
    longint hint;
    longint span;
    logic [TIME_W-1:0] step_ms;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 9);
      if (r == 0) tgt = '0;
      else if (r == 1) tgt = '1;
      else if (r < 6) tgt = $urandom_range(0, duty_max_r);
      else if (r < 8) begin
        span = longint'(min_dist_r) * 3;
        dg = $urandom_range(0, (span > 65535) ? 65535 : span);
        if ($urandom_range(0, 1)) dg = gen_last_tgt + dg;
        else dg = gen_last_tgt - dg;
        tgt = (dg < 0) ? 0 : ((dg > 65535) ? 16'hFFFF : TGT_W'(dg));
      end else tgt = $urandom();
      a = (tgt < duty_max_r) ? tgt : duty_max_r;
      b = (gen_last_tgt < duty_max_r) ? gen_last_tgt : duty_max_r;
      dg = (a > b) ? a - b : b - a;
      if (dg == 0) dg = 1;
      hint = (longint'(ramp_time_r) * longint'(ramp_step_r)) / dg;
      if (hint > 32'h3FFF_FFFF) hint = 32'h3FFF_FFFF;
      noisy = ($urandom_range(0, 9) == 0);
      len = $urandom_range(1, 20);
      for (k = 0; k < len && made < n; k++) begin
        if (noisy) begin
          tgt = $urandom();
          smooth = $urandom_range(0, 1);
        end else if (k == 0) begin
          smooth = ($urandom_range(0, 9) < 8);
        end else begin
          smooth = ($urandom_range(0, 9) == 0);
        end
        r = $urandom_range(0, 9);
        if (r < 2) step_ms = '0;
        else if (r < 7) step_ms = $urandom_range(0, hint);
        else if (r < 9) step_ms = $urandom_range(hint, hint * 3);
        else step_ms = $urandom();
        gen_ms = gen_ms + step_ms;
        add_req(tgt, gen_ms, smooth);
        made++;
      end
      gen_last_tgt = tgt;
    end
  endtask

  // register settings per phase: duty_max, ramp_step, min distance, ramp time
  int unsigned ph_max[PHASES];
  int unsigned ph_step[PHASES];
  int unsigned ph_min[PHASES];
  int unsigned ph_time[PHASES];

  initial begin
    int p;
    ph_max  = '{1023, 65535, 1, 4000, 65535, 0, 0};
    ph_step = '{1,    65535, 1, 200,  2000,  0, 0};
    ph_min  = '{16,   1,     1, 100,  500,   0, 0};
    ph_time = '{500,  65535, 1, 300,  2000,  0, 0};
    for (p = 5; p < PHASES; p++) begin
      ph_max[p]  = $urandom_range(1, 65535);
      ph_step[p] = $urandom_range(1, ph_max[p] / 16 + 1);
      ph_min[p]  = $urandom_range(1, 2000);
      ph_time[p] = $urandom_range(1, 65535);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: jumps, clamping, timed steps, hold-off, wrap, snap, short moves
    add_req(16'd0,    32'd0,          1'b0);
    add_req(16'hFFFF, 32'd5,          1'b0);
    add_req(16'd923,  32'd100,        1'b1);
    add_req(16'd923,  32'd103,        1'b0);
    add_req(16'd923,  32'd105,        1'b0);
    add_req(16'd950,  32'd110,        1'b0);
    add_req(16'd1015, 32'hFFFF_FFF0,  1'b0);
    add_req(16'd1015, 32'h0000_0002,  1'b0);
    add_req(16'd1017, 32'd7,          1'b0);
    add_req(16'd1000, 32'd8,          1'b0);
    add_req(16'd990,  32'd9,          1'b1);
    add_req(16'd990,  32'd10,         1'b1);
    add_req(16'd0,    32'hFFFF_FFFF,  1'b1);
    add_req(16'hFFFF, 32'h8000_0000,  1'b0);
    add_req(16'hAAAA, 32'h5555_5555,  1'b1);
    add_req(16'h5555, 32'hAAAA_AAAA,  1'b0);
    gen_ms = 32'hAAAA_AAAA;
    gen_last_tgt = 16'd1023;
    drain();

    for (p = 0; p < PHASES; p++) begin
      idle_pct = (p == 4) ? 0 : 38;
      cfg_write(REG_DUTY_MAX,  CFG_W'(ph_max[p]));
      cfg_write(REG_RAMP_STEP, CFG_W'(ph_step[p]));
      cfg_write(REG_MIN_DIST,  CFG_W'(ph_min[p]));
      cfg_write(REG_RAMP_TIME, CFG_W'(ph_time[p]));
      @(negedge clk);
      cfg_we <= 1'b0;
      gen_phase(ITEMS_PER_PHASE);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d transactions checked across %0d register settings", n_results,
             PHASES + 1);
    $display("tb: %0d timed steps, %0d ramp completions, %0d mismatches", n_steps,
             n_done, mismatches);
    if (mismatches == 0 && duty_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
